FILE: rtl/cylinder_mesh_generator_top_defines.svh
// assertion macros for the cylinder mesh generator
// depends on nothing; included by files that carry concurrent assertions
`ifndef CYLINDER_MESH_GENERATOR_TOP_DEFINES_SVH
`define CYLINDER_MESH_GENERATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define CMG_ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CMG_ASSERT(label, prop, msg) \
  `CMG_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define CMG_ASSERT_CLK(label, clk, rstn, prop, msg)
`define CMG_ASSERT(label, prop, msg)
`endif
`endif

FILE: rtl/cmg_pkg.sv
// shared constants, types and tables of the cylinder mesh generator
// no dependencies
package cmg_pkg;

  localparam int unsigned MAX_SLICES = 256;
  localparam int unsigned MAX_STACKS = 255;
  localparam int unsigned MIN_SLICES = 3;
  localparam int unsigned MIN_STACKS = 1;

  localparam int unsigned CORDIC_STEPS     = 16;
  localparam int unsigned CORDIC_PER_STAGE = 2;
  localparam int unsigned CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;

  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;
  localparam logic [24:0]        PI2_Q24      = 25'd26353589;
  localparam logic signed [15:0] ONE_Q14      = 16'sd16384;

  localparam int unsigned DIV_NUM_W = 33;
  localparam int unsigned DIV_DEN_W = 9;
  localparam int unsigned DIV_STEP  = 3;

  typedef enum logic [1:0] {
    REG_SLICE_COUNT = 2'd0,
    REG_STACK_COUNT = 2'd1,
    REG_RADIUS      = 2'd2,
    REG_HEIGHT      = 2'd3
  } cfg_reg_e;

  // per-item control that travels beside the arithmetic
  typedef struct packed {
    logic       mode;
    logic [7:0] ring;
    logic [7:0] slice;
    logic       bad;
    logic [1:0] quad;
    logic       axis;
  } side_t;

  function automatic logic signed [26:0] atan_q24(input int unsigned i);
    logic signed [26:0] v;
    case (i)
      0:       v = 27'sd13176795;
      1:       v = 27'sd7778716;
      2:       v = 27'sd4110060;
      3:       v = 27'sd2086331;
      4:       v = 27'sd1047214;
      5:       v = 27'sd524117;
      6:       v = 27'sd262123;
      7:       v = 27'sd131069;
      8:       v = 27'sd65536;
      9:       v = 27'sd32768;
      10:      v = 27'sd16384;
      11:      v = 27'sd8192;
      12:      v = 27'sd4096;
      13:      v = 27'sd2048;
      14:      v = 27'sd1024;
      15:      v = 27'sd512;
      default: v = 27'sd0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/cmg_div_pipe.sv
// pipelined restoring divider, STEP quotient bits per stage
// standalone; used by cylinder_mesh_generator_top
module cmg_div_pipe #(
  parameter int unsigned NUM_W = 33,
  parameter int unsigned DEN_W = 9,
  parameter int unsigned STEP  = 3
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quo_o
);

  localparam int unsigned STAGES = (NUM_W + STEP - 1) / STEP;
  localparam int unsigned PAD_W  = STAGES * STEP;

  logic [DEN_W-1:0] rem_q [STAGES];
  logic [PAD_W-1:0] wrk_q [STAGES];
  logic [DEN_W-1:0] den_q [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    logic [DEN_W-1:0] rem_in;
    logic [PAD_W-1:0] wrk_in;
    logic [DEN_W-1:0] den_in;
    logic [DEN_W-1:0] rem_d;
    logic [PAD_W-1:0] wrk_d;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign wrk_in = PAD_W'(num_i);
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign wrk_in = wrk_q[g-1];
      assign den_in = den_q[g-1];
    end

    // numerator bits shift out the top, quotient bits fill in at the bottom
    always_comb begin
      logic [DEN_W:0] t;
      rem_d = rem_in;
      wrk_d = wrk_in;
      for (int b = 0; b < STEP; b++) begin
        t     = {rem_d, wrk_d[PAD_W-1]};
        wrk_d = {wrk_d[PAD_W-2:0], 1'b0};
        if (t >= {1'b0, den_in}) begin
          rem_d    = DEN_W'(t - {1'b0, den_in});
          wrk_d[0] = 1'b1;
        end else begin
          rem_d = t[DEN_W-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        wrk_q[g] <= wrk_d;
        den_q[g] <= den_in;
      end
    end
  end

  assign quo_o = wrk_q[STAGES-1][NUM_W-1:0];

endmodule

FILE: rtl/cylinder_mesh_generator_top.sv
// cylinder mesh generator: vertex positions, normals and quad indices
// depends on cmg_pkg, cmg_div_pipe and cylinder_mesh_generator_top_defines.svh
//
//  channel  handshake                  payload
//  input    in_valid_i / in_ready_o    mode_i ring_i slice_i
//  output   out_valid_o / out_ready_i  pos_* norm_* tri_* bad_index_o
//  config   cfg_we_i                   cfg_idx_i cfg_data_i
//
// one transfer per cycle in each direction; the path runs through three entry
// stages, eleven divider stages, eight cordic stages (two rotations each)
// and three output stages.
// the whole pipeline advances together and holds when the output register
// is full and not taken; in_ready_o drops only then.
// reset empties the pipeline and loads slices 3, stacks 1, radius and height 0.
`include "cylinder_mesh_generator_top_defines.svh"

module cylinder_mesh_generator_top
  import cmg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic [7:0]         ring_i,
  input  logic [7:0]         slice_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] pos_x_o,
  output logic signed [16:0] pos_y_o,
  output logic [15:0]        pos_z_o,
  output logic signed [15:0] norm_x_o,
  output logic signed [15:0] norm_y_o,
  output logic [15:0]        tri_a0_o,
  output logic [15:0]        tri_a1_o,
  output logic [15:0]        tri_a2_o,
  output logic [15:0]        tri_b0_o,
  output logic [15:0]        tri_b1_o,
  output logic [15:0]        tri_b2_o,
  output logic               bad_index_o
);

  localparam int unsigned DIV_LAT = (DIV_NUM_W + DIV_STEP - 1) / DIV_STEP;

  // configuration, counts stored already clamped
  logic [8:0]  s_eff_q;
  logic [7:0]  t_eff_q;
  logic [15:0] radius_q;
  logic [15:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_eff_q  <= 9'(MIN_SLICES);
      t_eff_q  <= 8'(MIN_STACKS);
      radius_q <= '0;
      height_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SLICE_COUNT: begin
          if (cfg_data_i[8:0] < 9'(MIN_SLICES)) s_eff_q <= 9'(MIN_SLICES);
          else if (cfg_data_i[8:0] > 9'(MAX_SLICES)) s_eff_q <= 9'(MAX_SLICES);
          else s_eff_q <= cfg_data_i[8:0];
        end
        REG_STACK_COUNT: begin
          if (cfg_data_i[7:0] < 8'(MIN_STACKS)) t_eff_q <= 8'(MIN_STACKS);
          else if (cfg_data_i[7:0] > 8'(MAX_STACKS)) t_eff_q <= 8'(MAX_STACKS);
          else t_eff_q <= cfg_data_i[7:0];
        end
        REG_RADIUS: radius_q <= cfg_data_i;
        REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic o_vld_q;
  assign en         = ~o_vld_q | out_ready_i;
  assign in_ready_o = en;

  // stage a: input register
  logic       a_vld_q;
  logic       a_mode_q;
  logic [7:0] a_ring_q;
  logic [7:0] a_slice_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) a_vld_q <= 1'b0;
    else if (en) a_vld_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_mode_q  <= mode_i;
      a_ring_q  <= ring_i;
      a_slice_q <= slice_i;
    end
  end

  // stage b: quadrant and remainder of 4*slice over S, range check
  logic [9:0] slice4, s1, s2, s3, r10;
  logic       ge1, ge2, ge3;
  side_t      b_side_d;

  always_comb begin
    slice4 = {a_slice_q, 2'b00};
    s1     = {1'b0, s_eff_q};
    s2     = {s_eff_q, 1'b0};
    s3     = s1 + s2;
    ge1    = slice4 >= s1;
    ge2    = slice4 >= s2;
    ge3    = slice4 >= s3;
    b_side_d.mode  = a_mode_q;
    b_side_d.ring  = a_ring_q;
    b_side_d.slice = a_slice_q;
    if (ge3) begin
      b_side_d.quad = 2'd3;
      r10           = slice4 - s3;
    end else if (ge2) begin
      b_side_d.quad = 2'd2;
      r10           = slice4 - s2;
    end else if (ge1) begin
      b_side_d.quad = 2'd1;
      r10           = slice4 - s1;
    end else begin
      b_side_d.quad = 2'd0;
      r10           = slice4;
    end
    b_side_d.axis = (r10 == 10'd0);
    if (a_mode_q) b_side_d.bad = (a_ring_q >= t_eff_q) || ({1'b0, a_slice_q} >= s_eff_q);
    else          b_side_d.bad = (a_ring_q > t_eff_q) || ({1'b0, a_slice_q} >= s_eff_q);
  end

  logic       b_vld_q;
  side_t      b_side_q;
  logic [7:0] b_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) b_vld_q <= 1'b0;
    else if (en) b_vld_q <= a_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_side_q <= b_side_d;
      b_r_q    <= r10[7:0];
    end
  end

  // stage c: dividends for the angle and for z
  logic                 c_vld_q;
  side_t                c_side_q;
  logic [DIV_NUM_W-1:0] c_num_ang_q;
  logic [DIV_NUM_W-1:0] c_num_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) c_vld_q <= 1'b0;
    else if (en) c_vld_q <= b_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_side_q    <= b_side_q;
      c_num_ang_q <= DIV_NUM_W'(b_r_q * PI2_Q24);
      c_num_z_q   <= DIV_NUM_W'(b_side_q.ring * height_q);
    end
  end

  // divider stages
  logic [DIV_NUM_W-1:0] quo_ang, quo_z;

  cmg_div_pipe #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .STEP  (DIV_STEP)
  ) u_div_ang (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (c_num_ang_q),
    .den_i (s_eff_q),
    .quo_o (quo_ang)
  );

  cmg_div_pipe #(
    .NUM_W (DIV_NUM_W),
    .DEN_W (DIV_DEN_W),
    .STEP  (DIV_STEP)
  ) u_div_z (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (c_num_z_q),
    .den_i ({1'b0, t_eff_q}),
    .quo_o (quo_z)
  );

  logic  d_vld_q  [DIV_LAT];
  side_t d_side_q [DIV_LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DIV_LAT; i++) d_vld_q[i] <= 1'b0;
    end else if (en) begin
      d_vld_q[0] <= c_vld_q;
      for (int i = 1; i < DIV_LAT; i++) d_vld_q[i] <= d_vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_side_q[0] <= c_side_q;
      for (int i = 1; i < DIV_LAT; i++) d_side_q[i] <= d_side_q[i-1];
    end
  end

  // cordic stages
  logic               e_vld_q  [CORDIC_STAGES];
  side_t              e_side_q [CORDIC_STAGES];
  logic [15:0]        e_posz_q [CORDIC_STAGES];
  logic signed [32:0] e_x_q    [CORDIC_STAGES];
  logic signed [32:0] e_y_q    [CORDIC_STAGES];
  logic signed [26:0] e_z_q    [CORDIC_STAGES];

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    logic               vld_in;
    side_t              side_in;
    logic [15:0]        posz_in;
    logic signed [32:0] x_in, y_in, x_d, y_d;
    logic signed [26:0] z_in, z_d;

    if (g == 0) begin : g_first
      assign vld_in  = d_vld_q[DIV_LAT-1];
      assign side_in = d_side_q[DIV_LAT-1];
      assign posz_in = quo_z[15:0];
      assign x_in    = CORDIC_START;
      assign y_in    = '0;
      assign z_in    = $signed({2'b00, quo_ang[24:0]});
    end else begin : g_next
      assign vld_in  = e_vld_q[g-1];
      assign side_in = e_side_q[g-1];
      assign posz_in = e_posz_q[g-1];
      assign x_in    = e_x_q[g-1];
      assign y_in    = e_y_q[g-1];
      assign z_in    = e_z_q[g-1];
    end

    always_comb begin
      logic signed [32:0] dx, dy;
      x_d = x_in;
      y_d = y_in;
      z_d = z_in;
      for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
        dx = y_d >>> (g * CORDIC_PER_STAGE + j);
        dy = x_d >>> (g * CORDIC_PER_STAGE + j);
        if (!z_d[26]) begin
          x_d = x_d - dx;
          y_d = y_d + dy;
          z_d = z_d - atan_q24(g * CORDIC_PER_STAGE + j);
        end else begin
          x_d = x_d + dx;
          y_d = y_d - dy;
          z_d = z_d + atan_q24(g * CORDIC_PER_STAGE + j);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) e_vld_q[g] <= 1'b0;
      else if (en) e_vld_q[g] <= vld_in;
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        e_side_q[g] <= side_in;
        e_posz_q[g] <= posz_in;
        e_x_q[g]    <= x_d;
        e_y_q[g]    <= y_d;
        e_z_q[g]    <= z_d;
      end
    end
  end

  // r1: round to q1.14, clamp, rotate by quadrant
  logic signed [32:0] xr, yr;
  logic signed [15:0] c_u, s_u, cs_d, sn_d;

  always_comb begin
    xr = (e_x_q[CORDIC_STAGES-1] + 33'sd32768) >>> 16;
    yr = (e_y_q[CORDIC_STAGES-1] + 33'sd32768) >>> 16;
    if (xr > 33'sd16384)       c_u = ONE_Q14;
    else if (xr < -33'sd16384) c_u = -ONE_Q14;
    else                       c_u = xr[15:0];
    if (yr > 33'sd16384)       s_u = ONE_Q14;
    else if (yr < -33'sd16384) s_u = -ONE_Q14;
    else                       s_u = yr[15:0];
    // exact axis angles skip the rotation result
    if (e_side_q[CORDIC_STAGES-1].axis) begin
      c_u = ONE_Q14;
      s_u = '0;
    end
    case (e_side_q[CORDIC_STAGES-1].quad)
      2'd0: begin cs_d = c_u;  sn_d = s_u;  end
      2'd1: begin cs_d = -s_u; sn_d = c_u;  end
      2'd2: begin cs_d = -c_u; sn_d = -s_u; end
      default: begin cs_d = s_u; sn_d = -c_u; end
    endcase
  end

  logic               r1_vld_q;
  side_t              r1_side_q;
  logic [15:0]        r1_posz_q;
  logic signed [15:0] r1_cs_q, r1_sn_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r1_vld_q <= 1'b0;
    else if (en) r1_vld_q <= e_vld_q[CORDIC_STAGES-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_side_q <= e_side_q[CORDIC_STAGES-1];
      r1_posz_q <= e_posz_q[CORDIC_STAGES-1];
      r1_cs_q   <= cs_d;
      r1_sn_q   <= sn_d;
    end
  end

  // r2: scale by radius
  logic               r2_vld_q;
  side_t              r2_side_q;
  logic [15:0]        r2_posz_q;
  logic signed [15:0] r2_cs_q, r2_sn_q;
  logic signed [32:0] r2_px_q, r2_py_q;
  logic signed [16:0] rad_s;

  assign rad_s = $signed({1'b0, radius_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) r2_vld_q <= 1'b0;
    else if (en) r2_vld_q <= r1_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_side_q <= r1_side_q;
      r2_posz_q <= r1_posz_q;
      r2_cs_q   <= r1_cs_q;
      r2_sn_q   <= r1_sn_q;
      r2_px_q   <= r1_cs_q * rad_s + 33'sd8192;
      r2_py_q   <= r1_sn_q * rad_s + 33'sd8192;
    end
  end

  // r3: indices, field selection, output register
  logic [16:0] lo;
  logic [17:0] hi;
  logic [8:0]  nxt, slc9;

  always_comb begin
    slc9 = {1'b0, r2_side_q.slice};
    nxt  = (slc9 + 9'd1 == s_eff_q) ? 9'd0 : slc9 + 9'd1;
    lo   = 17'(r2_side_q.ring * s_eff_q);
    hi   = {1'b0, lo} + {9'd0, s_eff_q};
  end

  logic o_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_vld_q <= 1'b0;
    else if (en) o_vld_q <= r2_vld_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_mode_q    <= r2_side_q.mode;
      bad_index_o <= r2_side_q.bad;
      pos_x_o     <= '0;
      pos_y_o     <= '0;
      pos_z_o     <= '0;
      norm_x_o    <= '0;
      norm_y_o    <= '0;
      tri_a0_o    <= '0;
      tri_a1_o    <= '0;
      tri_a2_o    <= '0;
      tri_b0_o    <= '0;
      tri_b1_o    <= '0;
      tri_b2_o    <= '0;
      if (!r2_side_q.bad) begin
        if (!r2_side_q.mode) begin
          pos_x_o  <= r2_px_q[30:14];
          pos_y_o  <= r2_py_q[30:14];
          pos_z_o  <= r2_posz_q;
          norm_x_o <= r2_cs_q;
          norm_y_o <= r2_sn_q;
        end else begin
          tri_a0_o <= 16'({1'b0, lo} + {9'd0, slc9});
          tri_a1_o <= 16'({1'b0, lo} + {9'd0, nxt});
          tri_a2_o <= 16'(hi + {9'd0, slc9});
          tri_b0_o <= 16'({1'b0, lo} + {9'd0, nxt});
          tri_b1_o <= 16'(hi + {9'd0, nxt});
          tri_b2_o <= 16'(hi + {9'd0, slc9});
        end
      end
    end
  end

  assign out_valid_o = o_vld_q;

  `CMG_ASSERT(a_bad_zero, (out_valid_o && bad_index_o) |-> (pos_z_o == 16'd0 && tri_a0_o == 16'd0 && norm_x_o == 16'sd0), "flagged result carries data")
  `CMG_ASSERT(a_quad_rows, (out_valid_o && o_mode_q && !bad_index_o) |-> (tri_a2_o == 16'(tri_a0_o + s_eff_q) && tri_b0_o == tri_a1_o), "quad rows inconsistent")
  `CMG_ASSERT(a_stall_src, !in_ready_o |-> (out_valid_o && !out_ready_i), "pipeline held without output stall")
  `CMG_ASSERT(a_norm_range, (out_valid_o && !o_mode_q) |-> (norm_x_o <= 16'sd16384 && norm_x_o >= -16'sd16384 && norm_y_o <= 16'sd16384 && norm_y_o >= -16'sd16384), "normal outside unit range")

endmodule
